FILE: rtl/btb_pkg.sv
// Shared types, constants and helpers for the two-level branch predictor.
// No dependencies; used by btb_front, btb_back and the top level.
`default_nettype none
package btb_pkg;
   localparam int MAX_ENTRIES  = 32;
   localparam int INDEX_W      = $clog2(MAX_ENTRIES);
   localparam int MAX_HISTORY  = 8;
   localparam int CELLS        = 1 << MAX_HISTORY;
   localparam int ROW_W        = 2 * CELLS;
   localparam int MAX_TAG      = 25;
   localparam int ROWS         = MAX_ENTRIES + 1;
   localparam int ROW_AW       = $clog2(ROWS);
   localparam int GLOBAL_ROW   = MAX_ENTRIES;
   localparam int PC_GAP       = 4;
   localparam int PC_WORD_SHIFT = 2;
   localparam logic [1:0] BR_WNT = 2'd1;

   localparam logic [2:0] CSR_INDEX_BITS      = 3'd0;
   localparam logic [2:0] CSR_HISTORY_LENGTH  = 3'd1;
   localparam logic [2:0] CSR_TAG_WIDTH       = 3'd2;
   localparam logic [2:0] CSR_SHARED_HISTORY  = 3'd3;
   localparam logic [2:0] CSR_SHARED_COUNTERS = 3'd4;
   localparam logic [2:0] CSR_XOR_INDEXING    = 3'd5;

   localparam logic KIND_PREDICT = 1'b0;
   localparam logic KIND_UPDATE  = 1'b1;

   // clamped configuration as seen by the datapath
   typedef struct packed {
      logic [2:0]             ib;
      logic [4:0]             tw;
      logic [MAX_HISTORY-1:0] hmask;
      logic                   shared_history;
      logic                   shared_counters;
      logic                   use_xor;
   } cfg_type;

   // one decoded request in the queue
   typedef struct packed {
      logic                   kind;
      logic                   taken;
      logic                   flush;
      logic [31:0]            target;
      logic [31:0]            next_pc;
      logic [INDEX_W-1:0]     idx;
      logic [MAX_TAG-1:0]     tag;
      logic [MAX_HISTORY-1:0] word_lo;
   } item_type;

   function automatic logic [1:0] step_counter(input logic [1:0] c, input logic taken);
      logic [1:0] r;
      if (taken) r = (c == 2'd3) ? 2'd3 : c + 2'd1;
      else       r = (c == 2'd0) ? 2'd0 : c - 2'd1;
      return r;
   endfunction
endpackage
`default_nettype wire

FILE: rtl/btb_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module btb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

FILE: rtl/btb_front.sv
// Front end: decodes requests (index, tag, pc+4, flush) into a two-entry queue.
// Depends on btb_pkg.
`default_nettype none
module btb_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire btb_pkg::cfg_type  cfg,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_kind,
   input  wire logic [31:0]       req_branch_pc,
   input  wire logic [31:0]       req_resolved_target,
   input  wire logic              req_was_taken,
   input  wire logic [31:0]       req_earlier_guess,
   output btb_pkg::item_type      head,
   output logic                   head_valid,
   input  wire logic              pop
);
   btb_pkg::item_type q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic [31:0] word, shifted, tmask;
   btb_pkg::item_type dec;

   always_comb begin
      word    = req_branch_pc >> btb_pkg::PC_WORD_SHIFT;
      shifted = word >> cfg.ib;
      tmask   = (32'd1 << cfg.tw) - 32'd1;
      dec.kind    = req_kind;
      dec.taken   = req_was_taken;
      dec.target  = req_resolved_target;
      dec.next_pc = req_branch_pc + 32'(btb_pkg::PC_GAP);
      dec.flush   = req_was_taken ? (req_earlier_guess != req_resolved_target)
                                  : (req_earlier_guess != dec.next_pc);
      dec.idx     = btb_pkg::INDEX_W'(word & ((32'd1 << cfg.ib) - 32'd1));
      dec.tag     = btb_pkg::MAX_TAG'(shifted & tmask);
      dec.word_lo = word[btb_pkg::MAX_HISTORY-1:0];
   end

   assign req_stall  = (count_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign head       = q_ff[rd_ptr_ff];
   assign head_valid = (count_ff != 2'd0);

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) q_ff[wr_ptr_ff] <= dec;
   end
endmodule
`default_nettype wire

FILE: rtl/btb_back.sv
// Back end: entry lookup, counter row read/modify/write and result register.
// Depends on btb_pkg and btb_ram.
`default_nettype none
module btb_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire btb_pkg::cfg_type  cfg,
   input  wire btb_pkg::item_type head,
   input  wire logic              head_valid,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_guess_taken,
   output logic [31:0]            rsp_guess_destination,
   output logic                   rsp_flush
);
   localparam int HW = btb_pkg::MAX_HISTORY;

   typedef enum logic [1:0] {
      S_ISSUE = 2'b01,
      S_EXEC  = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic                   valid_ff  [btb_pkg::MAX_ENTRIES];
   logic [btb_pkg::MAX_TAG-1:0] tag_ff [btb_pkg::MAX_ENTRIES];
   logic [31:0]            target_ff [btb_pkg::MAX_ENTRIES];
   logic [HW-1:0]          lhist_ff  [btb_pkg::MAX_ENTRIES];
   logic [HW-1:0]          ghist_ff;
   logic                   row_ok_ff [btb_pkg::ROWS];

   btb_pkg::item_type      it_ff;
   logic [HW-1:0]          hist_ff, cell_ff;
   logic                   hit_ff, row_valid_ff;
   logic [btb_pkg::ROW_AW-1:0] row_addr_ff;

   logic                   rsp_valid_ff, rsp_taken_ff, rsp_flush_ff;
   logic [31:0]            rsp_dest_ff;

   // issue-side lookups
   logic [HW-1:0]          hist_sel, cell_norm, cell_sel, wlo;
   logic                   hit_sel;
   logic [btb_pkg::ROW_AW-1:0] row_addr;

   // exec-side
   logic [btb_pkg::ROW_W-1:0] rd_row, row_eff, new_row;
   logic [1:0]             ctr, ctr_base, ctr_new;
   logic [HW-1:0]          nh;
   logic                   do_upd, miss_upd, clear_row;

   assign pop = (state_ff == S_ISSUE) && head_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      hist_sel  = (cfg.shared_history ? ghist_ff : lhist_ff[head.idx]) & cfg.hmask;
      hit_sel   = valid_ff[head.idx] && (tag_ff[head.idx] == head.tag);
      wlo       = head.word_lo & cfg.hmask;
      cell_norm = cfg.use_xor ? (wlo ^ hist_sel) : hist_sel;
      // a miss with per-entry history restarts the history at zero
      if (head.kind == btb_pkg::KIND_UPDATE && !hit_sel && !cfg.shared_history)
         cell_sel = cfg.use_xor ? wlo : '0;
      else
         cell_sel = cell_norm;
      row_addr = cfg.shared_counters ? btb_pkg::ROW_AW'(btb_pkg::GLOBAL_ROW)
                                     : btb_pkg::ROW_AW'(head.idx);
   end

   always_comb begin
      row_eff   = row_valid_ff ? rd_row : {btb_pkg::CELLS{btb_pkg::BR_WNT}};
      ctr       = row_eff[2*cell_ff +: 2];
      do_upd    = (state_ff == S_EXEC) && (it_ff.kind == btb_pkg::KIND_UPDATE);
      miss_upd  = !hit_ff;
      clear_row = miss_upd && !cfg.shared_counters;
      ctr_base  = clear_row ? btb_pkg::BR_WNT : ctr;
      ctr_new   = btb_pkg::step_counter(ctr_base, it_ff.taken);
      nh        = ((hist_ff << 1) | HW'(it_ff.taken)) & cfg.hmask;
      new_row   = row_eff;
      for (int j = 0; j < btb_pkg::CELLS; j++) begin
         if (clear_row && ((HW'(j) & ~cfg.hmask) == '0))
            new_row[2*j +: 2] = btb_pkg::BR_WNT;
      end
      new_row[2*cell_ff +: 2] = ctr_new;
   end

   btb_ram #(.WIDTH(btb_pkg::ROW_W), .DEPTH(btb_pkg::ROWS)) u_rows (
      .clock   (clock),
      .wr_en   (do_upd),
      .wr_addr (row_addr_ff),
      .wr_data (new_row),
      .rd_en   (pop),
      .rd_addr (row_addr),
      .rd_data (rd_row)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_ISSUE: if (pop) state_in = S_EXEC;
         S_EXEC:  state_in = S_ISSUE;
         default: state_in = S_ISSUE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_ISSUE;
         rsp_valid_ff <= 1'b0;
         ghist_ff     <= '0;
         for (int i = 0; i < btb_pkg::MAX_ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
            lhist_ff[i] <= '0;
         end
         for (int i = 0; i < btb_pkg::ROWS; i++) row_ok_ff[i] <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_EXEC) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)    rsp_valid_ff <= 1'b0;
         if (do_upd) begin
            row_ok_ff[row_addr_ff] <= 1'b1;
            if (cfg.shared_history)  ghist_ff <= nh;
            else if (hit_ff)         lhist_ff[it_ff.idx] <= nh;
            else                     lhist_ff[it_ff.idx] <= HW'(it_ff.taken);
            if (miss_upd)            valid_ff[it_ff.idx] <= 1'b1;
         end
      end
      if (pop) begin
         it_ff        <= head;
         hist_ff      <= hist_sel;
         cell_ff      <= cell_sel;
         hit_ff       <= hit_sel;
         row_addr_ff  <= row_addr;
         row_valid_ff <= row_ok_ff[row_addr];
      end
      if (do_upd) begin
         target_ff[it_ff.idx] <= it_ff.target;
         if (miss_upd) tag_ff[it_ff.idx] <= it_ff.tag;
      end
      if (state_ff == S_EXEC) begin
         if (it_ff.kind == btb_pkg::KIND_PREDICT) begin
            rsp_taken_ff <= hit_ff && ctr[1];
            rsp_dest_ff  <= (hit_ff && ctr[1]) ? target_ff[it_ff.idx] : it_ff.next_pc;
            rsp_flush_ff <= 1'b0;
         end else begin
            rsp_taken_ff <= 1'b0;
            rsp_dest_ff  <= '0;
            rsp_flush_ff <= it_ff.flush;
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_guess_taken       = rsp_taken_ff;
   assign rsp_guess_destination = rsp_dest_ff;
   assign rsp_flush             = rsp_flush_ff;
endmodule
`default_nettype wire

FILE: rtl/btb_two_level_branch_predictor_unit.sv
// Top level of the two-level branch predictor: config registers, front, back.
// Depends on btb_pkg, btb_front, btb_back (and btb_ram through btb_back).
//
// Direct-mapped branch target buffer with 2-bit counter direction prediction.
// Each request is a predict or an update; each gives exactly one response.
// In the back end a request is first issued (S_ISSUE, counter row read) and then
// executed (S_EXEC, evaluate and write back); no new request is taken from the
// queue while one is in S_EXEC. A two-entry queue decouples the request side
// from the back end: requests keep being taken while a response waits, until
// the queue is full, but the back end starts the next request only once the
// response register is empty or its response is taken in that same cycle.
// Counter tables live in one
// row-wide RAM: one row of 256 counters per entry plus one row for the shared
// table, so clearing a local table on allocation is a single row write.
// Rows carry reset-cleared valid bits; there is no clearing pass after reset.
// Write CSRs only while the block is idle.
`default_nettype none
module btb_two_level_branch_predictor_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [4:0]  csr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [31:0] req_branch_pc,
   input  wire logic [31:0] req_resolved_target,
   input  wire logic        req_was_taken,
   input  wire logic [31:0] req_earlier_guess,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_guess_taken,
   output logic [31:0]      rsp_guess_destination,
   output logic             rsp_flush
);
   logic [2:0] index_bits_ff;
   logic [3:0] history_length_ff;
   logic [4:0] tag_width_ff;
   logic       shared_history_ff, shared_counters_ff, xor_indexing_ff;

   btb_pkg::cfg_type  cfg;
   btb_pkg::item_type head;
   logic              head_valid, pop;
   logic [3:0]        hl;

   always_ff @(posedge clock) begin
      if (reset) begin
         index_bits_ff      <= 3'd0;
         history_length_ff  <= 4'd1;
         tag_width_ff       <= 5'd0;
         shared_history_ff  <= 1'b0;
         shared_counters_ff <= 1'b0;
         xor_indexing_ff    <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            btb_pkg::CSR_INDEX_BITS:      index_bits_ff      <= csr_data[2:0];
            btb_pkg::CSR_HISTORY_LENGTH:  history_length_ff  <= csr_data[3:0];
            btb_pkg::CSR_TAG_WIDTH:       tag_width_ff       <= csr_data;
            btb_pkg::CSR_SHARED_HISTORY:  shared_history_ff  <= csr_data[0];
            btb_pkg::CSR_SHARED_COUNTERS: shared_counters_ff <= csr_data[0];
            btb_pkg::CSR_XOR_INDEXING:    xor_indexing_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   // saturate out-of-range settings; zero history length acts as one
   always_comb begin
      if (history_length_ff == 4'd0) hl = 4'd1;
      else if (history_length_ff > 4'(btb_pkg::MAX_HISTORY)) hl = 4'(btb_pkg::MAX_HISTORY);
      else hl = history_length_ff;
      cfg.ib = (index_bits_ff > 3'(btb_pkg::INDEX_W)) ? 3'(btb_pkg::INDEX_W) : index_bits_ff;
      cfg.tw = (tag_width_ff > 5'(btb_pkg::MAX_TAG)) ? 5'(btb_pkg::MAX_TAG) : tag_width_ff;
      cfg.hmask = btb_pkg::MAX_HISTORY'(((btb_pkg::MAX_HISTORY+1)'(1) << hl)
                                        - (btb_pkg::MAX_HISTORY+1)'(1));
      cfg.shared_history  = shared_history_ff;
      cfg.shared_counters = shared_counters_ff;
      cfg.use_xor         = xor_indexing_ff && shared_counters_ff;
   end

   btb_front u_front (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_branch_pc       (req_branch_pc),
      .req_resolved_target (req_resolved_target),
      .req_was_taken       (req_was_taken),
      .req_earlier_guess   (req_earlier_guess),
      .head                (head),
      .head_valid          (head_valid),
      .pop                 (pop)
   );

   btb_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg),
      .head                  (head),
      .head_valid            (head_valid),
      .pop                   (pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_guess_taken       (rsp_guess_taken),
      .rsp_guess_destination (rsp_guess_destination),
      .rsp_flush             (rsp_flush)
   );
endmodule
`default_nettype wire

FILE: rtl/btb_checker.sv
// Port-level checks for the branch predictor top level, bound to it below.
// Depends only on the top level's ports.
`default_nettype none
module btb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_guess_taken,
   input wire logic [31:0] rsp_guess_destination,
   input wire logic        rsp_flush
);
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_reset_ready: assert property (@(posedge clock) reset |=> !req_stall)
      else $error("request side stalled right after reset");

   a_taken_no_flush: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_guess_taken) |-> !rsp_flush)
      else $error("predict response carries flush");

   a_flush_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_flush) |-> (!rsp_guess_taken && rsp_guess_destination == 32'd0))
      else $error("update response carries guess fields");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_guess_destination)
                                    && $stable(rsp_flush) && $stable(rsp_guess_taken)))
      else $error("stalled response changed");
endmodule

bind btb_two_level_branch_predictor_unit btb_checker u_btb_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_stall             (req_stall),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_guess_taken       (rsp_guess_taken),
   .rsp_guess_destination (rsp_guess_destination),
   .rsp_flush             (rsp_flush)
);
`default_nettype wire
